@@ src/lzss_decompressor_unit_assert.svh @@
// Assertion macros for the LZSS decompressor.
// Used by the top level only; no other dependencies.
`ifndef LZSS_DECOMPRESSOR_UNIT_ASSERT_SVH
`define LZSS_DECOMPRESSOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define LZSSD_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("lzssd assertion failed");
`define LZSSD_NEVER(lbl, clk_s, rst_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(expr)) \
    else $error("lzssd forbidden condition seen");
`else
`define LZSSD_ASSERT(lbl, clk_s, rst_s, prop)
`define LZSSD_NEVER(lbl, clk_s, rst_s, expr)
`endif

`endif

@@ src/lzssd_pkg.sv @@
// Shared types and constants for the LZSS decompressor.
// No dependencies.
`default_nettype none

package lzssd_pkg;

  localparam int HISTORY_DEPTH_DEF    = 4096;
  localparam int MIN_MATCH_OFFSET_DEF = 2;
  localparam int BYTE_W               = 8;
  localparam int COUNT_W              = 21;
  localparam int FLAGS_W              = 4;
  localparam int DIST_W               = 12;

  localparam logic [COUNT_W-1:0] MAX_OUT_RESET = 21'h100000;
  localparam logic [FLAGS_W-1:0] FLAGS_PER_BYTE = 4'd8;
  localparam logic [BYTE_W-1:0]  FLAG_LIT_MASK  = 8'h80;
  localparam logic [BYTE_W-1:0]  DIST_HI_MASK   = 8'hf0;
  localparam logic [BYTE_W-1:0]  LEN_CODE_MASK  = 8'h0f;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_LIMIT = 2'd3
  } kind_t;

  // stop cause shares the kind codes; data code means still running
  localparam kind_t STOP_RUN = KIND_DATA;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    kind_t              kind;
    logic [COUNT_W-1:0] count;
    logic               run_last;
  } out_word_t;

  typedef struct packed {
    logic we;
    logic re;
  } hist_ctl_t;

endpackage

`default_nettype wire

@@ src/lzss_decompressor_unit.sv @@
// LZSS decompressor, 4k-window style stream decoder: usage notes.
// Input channel (in_valid/in_stall, in_byte, in_last) takes one compressed
// word per accepted transfer. Output channel (out_valid/out_stall) gives
// result words: decoded bytes (kind data) and one status word per stream.
// A word is transferred on a rising edge with valid high and stall low.
// Flow: the input is taken only while the sequencer is idle. Each word is
// decoded first; a literal is then emitted and written to history, and a
// match copies each byte with one history read then one write. A word
// marked last is followed by the status word for its stream.
// An output register sits between sequencer and receiver; a stall holds
// the word there and the sequencer waits on it. Reset (rst, synchronous)
// returns the stream state to the start of a stream and the limit register
// to 1048576. History needs no clearing. The user must write the limit
// register only while idle (cfg_wr_en/cfg_wr_data); it is not enforced.
// Depends on lzssd_pkg, lzssd_ctrl, lzssd_hist_mem, lzssd_out_reg.
`default_nettype none
`include "lzss_decompressor_unit_assert.svh"

module lzss_decompressor_unit #(
  parameter int HISTORY_DEPTH    = lzssd_pkg::HISTORY_DEPTH_DEF,
  parameter int MIN_MATCH_OFFSET = lzssd_pkg::MIN_MATCH_OFFSET_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [lzssd_pkg::COUNT_W-1:0]  cfg_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [lzssd_pkg::BYTE_W-1:0]   in_byte,
  input  wire logic                           in_last,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [lzssd_pkg::BYTE_W-1:0]   out_byte,
  output logic      [1:0]                     kind,
  output logic      [lzssd_pkg::COUNT_W-1:0]  total_count,
  output logic                                run_last
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  logic                         out_free;
  logic                         emit;
  lzssd_pkg::out_word_t         emit_word;
  lzssd_pkg::out_word_t         out_word;
  lzssd_pkg::hist_ctl_t         hist_ctl;
  logic [AW-1:0]                hist_waddr;
  logic [AW-1:0]                hist_raddr;
  logic [lzssd_pkg::BYTE_W-1:0] hist_wdata;
  logic [lzssd_pkg::BYTE_W-1:0] hist_rdata;

  lzssd_ctrl #(
    .HISTORY_DEPTH    (HISTORY_DEPTH),
    .MIN_MATCH_OFFSET (MIN_MATCH_OFFSET)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .out_free    (out_free),
    .emit        (emit),
    .emit_word   (emit_word),
    .hist_ctl    (hist_ctl),
    .hist_waddr  (hist_waddr),
    .hist_wdata  (hist_wdata),
    .hist_raddr  (hist_raddr),
    .hist_rdata  (hist_rdata)
  );

  lzssd_hist_mem #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .ctl   (hist_ctl),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  lzssd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_word (emit_word),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign out_byte    = out_word.data;
  assign kind        = out_word.kind;
  assign total_count = out_word.count;
  assign run_last    = out_word.run_last;

  `LZSSD_ASSERT(a_busy_after_take, clk, rst, in_valid && !in_stall |=> in_stall)
  `LZSSD_ASSERT(a_status_ends_run, clk, rst,
                out_valid && kind != lzssd_pkg::KIND_DATA |-> run_last)
  `LZSSD_NEVER(a_data_no_count, clk, rst,
               out_valid && kind == lzssd_pkg::KIND_DATA && total_count != '0)

endmodule

`default_nettype wire

@@ src/lzssd_hist_mem.sv @@
// History buffer: one write port, one registered read port.
// Depends on lzssd_pkg.
`default_nettype none

module lzssd_hist_mem #(
  parameter int HISTORY_DEPTH = lzssd_pkg::HISTORY_DEPTH_DEF,
  localparam int AW = $clog2(HISTORY_DEPTH)
) (
  input  wire logic                          clk,
  input  wire lzssd_pkg::hist_ctl_t          ctl,
  input  wire logic [AW-1:0]                 waddr,
  input  wire logic [lzssd_pkg::BYTE_W-1:0]  wdata,
  input  wire logic [AW-1:0]                 raddr,
  output logic      [lzssd_pkg::BYTE_W-1:0]  rdata
);

  logic [lzssd_pkg::BYTE_W-1:0] mem [HISTORY_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/lzssd_out_reg.sv @@
// Output register for result words, valid/stall handshake.
// Depends on lzssd_pkg.
`default_nettype none

module lzssd_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire lzssd_pkg::out_word_t push_word,
  output logic                      free,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output lzssd_pkg::out_word_t      out_word
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && free) begin
      out_word <= push_word;
    end
  end

endmodule

`default_nettype wire

@@ src/lzssd_ctrl.sv @@
// Sequencer: token decode, match copy loop, limit and distance checks.
// Depends on lzssd_pkg; drives lzssd_hist_mem and lzssd_out_reg.
`default_nettype none

module lzssd_ctrl #(
  parameter int HISTORY_DEPTH    = lzssd_pkg::HISTORY_DEPTH_DEF,
  parameter int MIN_MATCH_OFFSET = lzssd_pkg::MIN_MATCH_OFFSET_DEF,
  localparam int AW    = $clog2(HISTORY_DEPTH),
  localparam int LEN_W = $clog2(MIN_MATCH_OFFSET + 17)
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [lzssd_pkg::COUNT_W-1:0]  cfg_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [lzssd_pkg::BYTE_W-1:0]   in_byte,
  input  wire logic                           in_last,
  input  wire logic                           out_free,
  output logic                                emit,
  output lzssd_pkg::out_word_t                emit_word,
  output lzssd_pkg::hist_ctl_t                hist_ctl,
  output logic      [AW-1:0]                  hist_waddr,
  output logic      [lzssd_pkg::BYTE_W-1:0]   hist_wdata,
  output logic      [AW-1:0]                  hist_raddr,
  input  wire logic [lzssd_pkg::BYTE_W-1:0]   hist_rdata
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_LIT    = 6'b000100,
    ST_RD     = 6'b001000,
    ST_WR     = 6'b010000,
    ST_STATUS = 6'b100000
  } state_t;

  localparam logic [AW:0] DEPTH_EXT = (AW+1)'(HISTORY_DEPTH);
  localparam logic [AW-1:0] PTR_LAST = AW'(HISTORY_DEPTH - 1);
  localparam logic [LEN_W-1:0] LEN_BIAS = LEN_W'(MIN_MATCH_OFFSET + 1);

  state_t state, state_next;
  logic [lzssd_pkg::COUNT_W-1:0] max_output_bytes;
  logic [lzssd_pkg::COUNT_W-1:0] out_position, out_position_next;
  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [lzssd_pkg::BYTE_W-1:0] flag_bits, flag_bits_next;
  logic [lzssd_pkg::FLAGS_W-1:0] flags_left, flags_left_next;
  logic token_phase, token_phase_next;
  logic [lzssd_pkg::BYTE_W-1:0] match_high_byte, match_high_byte_next;
  lzssd_pkg::kind_t stop_cause, stop_cause_next;
  logic [LEN_W-1:0] copy_left, copy_left_next;
  logic [lzssd_pkg::BYTE_W-1:0] cur_byte;
  logic cur_last;

  // shared limit comparator
  logic [lzssd_pkg::COUNT_W-1:0] cmp_pos;
  logic lim_hit;
  logic [lzssd_pkg::COUNT_W-1:0] pos_inc;
  logic [lzssd_pkg::DIST_W-1:0] match_dist;
  logic [AW:0] src_diff;
  logic [AW-1:0] wr_ptr_inc, rd_ptr_inc;
  state_t state_after;
  lzssd_pkg::kind_t stop_now;

  assign pos_inc    = out_position + lzssd_pkg::COUNT_W'(1);
  assign cmp_pos    = (state == ST_DECODE) ? out_position : pos_inc;
  assign lim_hit    = cmp_pos >= max_output_bytes;
  assign match_dist = {match_high_byte[7:4], cur_byte};
  assign src_diff   = {1'b0, wr_ptr} - (AW+1)'(match_dist);
  assign wr_ptr_inc = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + AW'(1);
  assign rd_ptr_inc = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + AW'(1);
  assign state_after = cur_last ? ST_STATUS : ST_IDLE;
  assign stop_now = (stop_cause == lzssd_pkg::STOP_RUN && lim_hit) ?
                    lzssd_pkg::KIND_LIMIT : stop_cause;
  assign in_stall = (state != ST_IDLE);

  assign hist_waddr = wr_ptr;
  assign hist_raddr = rd_ptr;
  assign hist_wdata = (state == ST_LIT) ? cur_byte : hist_rdata;

  always_comb begin
    state_next           = state;
    out_position_next    = out_position;
    wr_ptr_next          = wr_ptr;
    rd_ptr_next          = rd_ptr;
    flag_bits_next       = flag_bits;
    flags_left_next      = flags_left;
    token_phase_next     = token_phase;
    match_high_byte_next = match_high_byte;
    stop_cause_next      = stop_cause;
    copy_left_next       = copy_left;
    emit                 = 1'b0;
    emit_word.data       = hist_wdata;
    emit_word.kind       = lzssd_pkg::KIND_DATA;
    emit_word.count      = '0;
    emit_word.run_last   = 1'b0;
    hist_ctl.we          = 1'b0;
    hist_ctl.re          = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end

      ST_DECODE: begin
        stop_cause_next = stop_now;
        state_next      = state_after;
        if (stop_now == lzssd_pkg::STOP_RUN) begin
          if (token_phase) begin
            token_phase_next = 1'b0;
            if (match_dist == '0 || lzssd_pkg::COUNT_W'(match_dist) > out_position) begin
              stop_cause_next = lzssd_pkg::KIND_ERROR;
            end else begin
              copy_left_next = LEN_W'(match_high_byte & lzssd_pkg::LEN_CODE_MASK) + LEN_BIAS;
              rd_ptr_next    = src_diff[AW] ? AW'(src_diff + DEPTH_EXT) : src_diff[AW-1:0];
              state_next     = ST_RD;
            end
          end else if (flags_left == '0) begin
            flag_bits_next  = cur_byte;
            flags_left_next = lzssd_pkg::FLAGS_PER_BYTE;
          end else begin
            flag_bits_next  = {flag_bits[6:0], 1'b0};
            flags_left_next = flags_left - lzssd_pkg::FLAGS_W'(1);
            if ((flag_bits & lzssd_pkg::FLAG_LIT_MASK) != '0) begin
              state_next = ST_LIT;
            end else begin
              match_high_byte_next = cur_byte;
              token_phase_next     = 1'b1;
            end
          end
        end
      end

      ST_LIT: begin
        if (out_free) begin
          emit               = 1'b1;
          emit_word.run_last = !cur_last;
          hist_ctl.we        = 1'b1;
          out_position_next  = pos_inc;
          wr_ptr_next        = wr_ptr_inc;
          if (lim_hit) begin
            stop_cause_next = lzssd_pkg::KIND_LIMIT;
          end
          state_next = state_after;
        end
      end

      ST_RD: begin
        hist_ctl.re = 1'b1;
        state_next  = ST_WR;
      end

      ST_WR: begin
        if (out_free) begin
          emit              = 1'b1;
          hist_ctl.we       = 1'b1;
          out_position_next = pos_inc;
          wr_ptr_next       = wr_ptr_inc;
          rd_ptr_next       = rd_ptr_inc;
          copy_left_next    = copy_left - LEN_W'(1);
          if (lim_hit) begin
            stop_cause_next = lzssd_pkg::KIND_LIMIT;
          end
          if (lim_hit || copy_left == LEN_W'(1)) begin
            emit_word.run_last = !cur_last;
            state_next         = state_after;
          end else begin
            state_next = ST_RD;
          end
        end
      end

      ST_STATUS: begin
        if (out_free) begin
          emit               = 1'b1;
          emit_word.data     = '0;
          emit_word.kind     = (stop_cause == lzssd_pkg::STOP_RUN) ?
                               lzssd_pkg::KIND_END : stop_cause;
          emit_word.count    = out_position;
          emit_word.run_last = 1'b1;
          out_position_next    = '0;
          wr_ptr_next          = '0;
          flag_bits_next       = '0;
          flags_left_next      = '0;
          token_phase_next     = 1'b0;
          match_high_byte_next = '0;
          stop_cause_next      = lzssd_pkg::STOP_RUN;
          state_next           = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      max_output_bytes <= lzssd_pkg::MAX_OUT_RESET;
      out_position     <= '0;
      wr_ptr           <= '0;
      flag_bits        <= '0;
      flags_left       <= '0;
      token_phase      <= 1'b0;
      match_high_byte  <= '0;
      stop_cause       <= lzssd_pkg::STOP_RUN;
    end else begin
      state            <= state_next;
      out_position     <= out_position_next;
      wr_ptr           <= wr_ptr_next;
      flag_bits        <= flag_bits_next;
      flags_left       <= flags_left_next;
      token_phase      <= token_phase_next;
      match_high_byte  <= match_high_byte_next;
      stop_cause       <= stop_cause_next;
      if (cfg_wr_en) begin
        max_output_bytes <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr    <= rd_ptr_next;
    copy_left <= copy_left_next;
    if (state == ST_IDLE && in_valid) begin
      cur_byte <= in_byte;
      cur_last <= in_last;
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_lzss_decompressor_unit.sv @@
// Self-checking testbench for lzss_decompressor_unit: a directed table, then random streams,
// all scored against an in-bench LZSS decoder.
// Depends on lzssd_pkg and the RTL under src/.
`timescale 1ns / 100ps

module tb_lzss_decompressor_unit;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int FEED_TARGET = 430;
  localparam int SETTLE_CYCLES = 12;
  localparam int TAIL_CYCLES = 40;
  localparam int PRESSURE_CYCLES = 300;
  localparam int N_DIR = 30;

  typedef enum {ROW_WORD, ROW_LIMIT} row_op_t;

  typedef struct {
    row_op_t                       op;
    logic [7:0]                    data;
    logic                          last;
    logic                          chk;
    lzssd_pkg::kind_t              ekind;
    logic [lzssd_pkg::COUNT_W-1:0] ecount;
    logic [lzssd_pkg::COUNT_W-1:0] limit;
  } dir_row_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_wr_en;
  logic [lzssd_pkg::COUNT_W-1:0] cfg_wr_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [lzssd_pkg::BYTE_W-1:0]  in_byte;
  logic                          in_last;
  logic                          out_valid;
  logic                          out_stall;
  logic [lzssd_pkg::BYTE_W-1:0]  out_byte;
  logic [1:0]                    kind;
  logic [lzssd_pkg::COUNT_W-1:0] total_count;
  logic                          run_last;

  // decoder model state
  logic [7:0]                    hist_mem [0:lzssd_pkg::HISTORY_DEPTH_DEF-1];
  logic [lzssd_pkg::COUNT_W-1:0] out_pos;
  logic [7:0]                    flag_sr;
  logic [3:0]                    flags_rem;
  logic                          want_low;
  logic [7:0]                    hi_byte;
  lzssd_pkg::kind_t              stop;
  logic [lzssd_pkg::COUNT_W-1:0] max_out;

  lzssd_pkg::out_word_t due_words [$];
  lzssd_pkg::out_word_t got_exp;
  dir_row_t    dir_rows [N_DIR];
  logic [7:0]  gen_lo;
  int          fed;
  int          n_mismatch;
  int unsigned cycle_count;
  int          stall_left;
  logic        rx_quiet;
  logic        pressure_hold;
  logic        random_phase;

  lzss_decompressor_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .kind        (kind),
    .total_count (total_count),
    .run_last    (run_last)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    n_mismatch++;
    $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  function automatic void clear_stream();
    out_pos = '0;
    flag_sr = '0;
    flags_rem = '0;
    want_low = 1'b0;
    hi_byte = '0;
    stop = lzssd_pkg::STOP_RUN;
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    lzssd_pkg::out_word_t w;
    hist_mem[out_pos % lzssd_pkg::HISTORY_DEPTH_DEF] = b;
    out_pos = out_pos + 1'b1;
    if (out_pos >= max_out) stop = lzssd_pkg::KIND_LIMIT;
    w.data = b;
    w.kind = lzssd_pkg::KIND_DATA;
    w.count = '0;
    w.run_last = 1'b0;
    due_words.push_back(w);
  endfunction

  task automatic decode_word(input logic [7:0] b, input logic last,
                             output lzssd_pkg::out_word_t status);
    int n_before;
    int len;
    int k;
    logic [11:0] match_dist;
    logic [lzssd_pkg::COUNT_W-1:0] src;
    logic lit;
    n_before = due_words.size();
    status = '0;
    if (stop == lzssd_pkg::STOP_RUN && out_pos >= max_out) stop = lzssd_pkg::KIND_LIMIT;
    if (stop == lzssd_pkg::STOP_RUN) begin
      if (want_low) begin
        match_dist = {hi_byte[7:4], b};
        len = int'(hi_byte & lzssd_pkg::LEN_CODE_MASK) + lzssd_pkg::MIN_MATCH_OFFSET_DEF + 1;
        want_low = 1'b0;
        if (match_dist == 0 || match_dist > out_pos) begin
          stop = lzssd_pkg::KIND_ERROR;
        end else begin
          for (k = 0; k < len && stop == lzssd_pkg::STOP_RUN; k++) begin
            src = out_pos - match_dist;
            emit_byte(hist_mem[src % lzssd_pkg::HISTORY_DEPTH_DEF]);
          end
        end
      end else if (flags_rem == 0) begin
        flag_sr = b;
        flags_rem = lzssd_pkg::FLAGS_PER_BYTE;
      end else begin
        lit = (flag_sr & lzssd_pkg::FLAG_LIT_MASK) != 0;
        flag_sr = flag_sr << 1;
        flags_rem = flags_rem - 1'b1;
        if (lit) emit_byte(b);
        else begin
          hi_byte = b;
          want_low = 1'b1;
        end
      end
    end
    if (last) begin
      status.data = '0;
      status.kind = (stop == lzssd_pkg::STOP_RUN) ? lzssd_pkg::KIND_END : stop;
      status.count = out_pos;
      status.run_last = 1'b0;
      due_words.push_back(status);
      clear_stream();
    end
    if (due_words.size() > n_before) due_words[due_words.size()-1].run_last = 1'b1;
  endtask

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  task automatic send_word(input logic [7:0] b, input logic last, input bit quiet);
    int gap;
    gap = quiet ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic set_limit(input logic [lzssd_pkg::COUNT_W-1:0] v);
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_out = v;
  endtask

  // next byte of a stream from the current decoder state; some match distances are invalid
  task automatic pick_byte(output logic [7:0] b);
    int span;
    logic [11:0] d;
    if (stop != lzssd_pkg::STOP_RUN || flags_rem == 0 || flag_sr[7]) begin
      b = 8'($urandom);
      if (stop == lzssd_pkg::STOP_RUN && !want_low && flags_rem == 0 &&
          $urandom_range(0, 1) == 0)
        b = 8'($urandom) & 8'($urandom);
    end
    if (stop == lzssd_pkg::STOP_RUN && want_low) begin
      b = gen_lo;
    end else if (stop == lzssd_pkg::STOP_RUN && flags_rem != 0 && !flag_sr[7]) begin
      span = (out_pos > 4095) ? 4095 : int'(out_pos);
      if (span == 0 || $urandom_range(0, 11) == 0) begin
        if ($urandom_range(0, 1) == 0 || out_pos >= 4095) d = '0;
        else d = 12'($urandom_range(int'(out_pos) + 1, 4095));
      end else if ($urandom_range(0, 1) == 0) begin
        d = 12'($urandom_range(1, (span < 20) ? span : 20));
      end else begin
        d = 12'($urandom_range(1, span));
      end
      b = {d[11:8], 4'($urandom)};
      gen_lo = d[7:0];
    end
  endtask

  task automatic run_stream();
    int r;
    int n_items;
    int i;
    bit quiet;
    bit junk;
    logic [7:0] b;
    logic last;
    lzssd_pkg::out_word_t status;
    r = $urandom_range(0, 23);
    if (r < 3) n_items = $urandom_range(1, 4);
    else if (r < 7) n_items = $urandom_range(100, 180);
    else n_items = $urandom_range(5, 50);
    if (n_items > FEED_TARGET - fed) n_items = FEED_TARGET - fed;
    quiet = ($urandom_range(0, 3) == 0);
    junk = ($urandom_range(0, 11) == 0);
    for (i = 0; i < n_items; i++) begin
      if (junk || $urandom_range(0, 33) == 0) b = 8'($urandom);
      else pick_byte(b);
      last = (i == n_items - 1);
      fed++;
      send_word(b, last, quiet);
      decode_word(b, last, status);
    end
  endtask

  function automatic logic [lzssd_pkg::COUNT_W-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return lzssd_pkg::MAX_OUT_RESET;
    if (r < 70) return lzssd_pkg::COUNT_W'($urandom_range(1, 40));
    return lzssd_pkg::COUNT_W'($urandom_range(41, 3000));
  endfunction

  // stimulus
  initial begin
    lzssd_pkg::out_word_t status;
    int i;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_byte = '0;
    in_last = 1'b0;
    random_phase = 1'b0;
    fed = 0;
    n_mismatch = 0;
    cycle_count = 0;
    gen_lo = '0;
    for (i = 0; i < lzssd_pkg::HISTORY_DEPTH_DEF; i++) hist_mem[i] = '0;
    clear_stream();
    max_out = lzssd_pkg::MAX_OUT_RESET;
    dir_rows = '{
      // literals at both extremes, a full-length copy, then a distance past the start
      '{ROW_WORD,  8'hE0, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd0},
      '{ROW_WORD,  8'h00, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd0},
      '{ROW_WORD,  8'hFF, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd0},
      '{ROW_WORD,  8'h41, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd0},
      '{ROW_WORD,  8'h0F, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd0},
      '{ROW_WORD,  8'h03, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd0},
      '{ROW_WORD,  8'hF0, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd0},
      '{ROW_WORD,  8'hFF, 1'b1, 1'b1, lzssd_pkg::KIND_ERROR, 21'd21, 21'd0},
      // zero distance
      '{ROW_WORD,  8'h80, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd0},
      '{ROW_WORD,  8'h12, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd0},
      '{ROW_WORD,  8'h00, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd0},
      '{ROW_WORD,  8'h00, 1'b1, 1'b1, lzssd_pkg::KIND_ERROR, 21'd1,  21'd0},
      // flag byte alone, then a match high byte left open
      '{ROW_WORD,  8'h33, 1'b1, 1'b1, lzssd_pkg::KIND_END,   21'd0,  21'd0},
      '{ROW_WORD,  8'h00, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd0},
      '{ROW_WORD,  8'h21, 1'b1, 1'b1, lzssd_pkg::KIND_END,   21'd0,  21'd0},
      // stream ends exactly on the limit
      '{ROW_LIMIT, 8'h00, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd1},
      '{ROW_WORD,  8'hFF, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd0},
      '{ROW_WORD,  8'h7E, 1'b1, 1'b1, lzssd_pkg::KIND_LIMIT, 21'd1,  21'd0},
      // copy cut short by the limit
      '{ROW_LIMIT, 8'h00, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd5},
      '{ROW_WORD,  8'h80, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd0},
      '{ROW_WORD,  8'h10, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd0},
      '{ROW_WORD,  8'h0F, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd0},
      '{ROW_WORD,  8'h01, 1'b1, 1'b1, lzssd_pkg::KIND_LIMIT, 21'd5,  21'd0},
      // limit lowered under the position mid-stream
      '{ROW_LIMIT, 8'h00, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'h100000},
      '{ROW_WORD,  8'hFF, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd0},
      '{ROW_WORD,  8'h01, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd0},
      '{ROW_WORD,  8'h02, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd0},
      '{ROW_LIMIT, 8'h00, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd1},
      '{ROW_WORD,  8'h03, 1'b0, 1'b0, lzssd_pkg::KIND_DATA,  21'd0,  21'd0},
      '{ROW_WORD,  8'h04, 1'b1, 1'b1, lzssd_pkg::KIND_LIMIT, 21'd2,  21'd0}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].op == ROW_LIMIT) begin
        set_limit(dir_rows[i].limit);
      end else begin
        send_word(dir_rows[i].data, dir_rows[i].last, 1'b0);
        decode_word(dir_rows[i].data, dir_rows[i].last, status);
        fed++;
        if (dir_rows[i].chk && (status.kind !== dir_rows[i].ekind ||
                                status.count !== dir_rows[i].ecount))
          flag_mismatch($sformatf("row %0d status %0d/%0d, table says %0d/%0d", i,
                                  status.kind, status.count, dir_rows[i].ekind,
                                  dir_rows[i].ecount));
      end
    end

    set_limit(lzssd_pkg::MAX_OUT_RESET);
    random_phase <= 1'b1;
    while (fed < FEED_TARGET) begin
      run_stream();
      if ($urandom_range(0, 2) == 0) set_limit(pick_limit());
    end
    in_valid <= 1'b0;

    while (due_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    pressure_hold = 1'b0;
    wait (random_phase);
    repeat (50) @(posedge clk);
    pressure_hold <= 1'b1;
    repeat (PRESSURE_CYCLES) @(posedge clk);
    pressure_hold <= 1'b0;
  end

  // receiver: check, then pick next stall
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    rx_quiet = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_valid && !out_stall) begin
          if (due_words.size() == 0) begin
            flag_mismatch($sformatf("unexpected word %h/%0d/%0d/%b", out_byte, kind,
                                    total_count, run_last));
          end else begin
            got_exp = due_words.pop_front();
            if (out_byte !== got_exp.data || kind !== got_exp.kind ||
                total_count !== got_exp.count || run_last !== got_exp.run_last)
              flag_mismatch($sformatf("got %h/%0d/%0d/%b want %h/%0d/%0d/%b",
                                      out_byte, kind, total_count, run_last,
                                      got_exp.data, got_exp.kind, got_exp.count,
                                      got_exp.run_last));
          end
        end
        if ($urandom_range(0, 199) == 0) rx_quiet = ~rx_quiet;
        if (stall_left != 0) begin
          stall_left--;
        end else if (!rx_quiet) begin
          case ($urandom_range(0, 99)) inside
            [0:59]:  stall_left = 0;
            [60:91]: stall_left = $urandom_range(1, 3);
            default: stall_left = $urandom_range(8, 25);
          endcase
        end
        out_stall <= pressure_hold || (stall_left != 0);
      end
    end
  end

endmodule

@@ files.f @@
+incdir+src
src/lzssd_pkg.sv
src/lzssd_hist_mem.sv
src/lzssd_out_reg.sv
src/lzssd_ctrl.sv
src/lzss_decompressor_unit.sv
dv/tb_lzss_decompressor_unit.sv
